### rtl/saturating_drive_with_ewma_trip_macros.svh
// ----------------------------------------------------------------------------
// saturating drive assertion macros
// shared property forms for the port checker, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef SATURATING_DRIVE_WITH_EWMA_TRIP_MACROS_SVH
`define SATURATING_DRIVE_WITH_EWMA_TRIP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SWET_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swet check failed");

// consequent must hold in the cycle after the antecedent
`define SWET_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swet check failed");

`endif

### rtl/swet_pkg.sv
// ----------------------------------------------------------------------------
// swet_pkg
// shared widths and the multiplier request type
// ----------------------------------------------------------------------------
package swet_pkg;

	localparam int CA_W   = 24;
	localparam int VAR_W  = 32;
	localparam int MUL_W  = 27;
	localparam int PROD_W = 2 * MUL_W;

	typedef struct packed {
		logic                     en;
		logic signed [MUL_W-1:0]  a;
		logic signed [MUL_W-1:0]  b;
	} mul_req_t;

endpackage

### rtl/swet_if.sv
// ----------------------------------------------------------------------------
// swet channel interfaces
// sample and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface swet_in_if;
	logic                             valid;
	logic                             ready;
	logic                             req_type;
	logic signed [swet_pkg::CA_W-1:0] ctrl_sample;
	logic                             sample_invalid;

	modport source (output valid, req_type, ctrl_sample, sample_invalid, input ready);
	modport sink   (input valid, req_type, ctrl_sample, sample_invalid, output ready);
endinterface

interface swet_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [swet_pkg::CA_W-1:0]  drive_value;
	logic                              drive_written;
	logic signed [swet_pkg::CA_W-1:0]  mean_value;
	logic        [swet_pkg::VAR_W-1:0] var_value;
	logic                              trip_flag;
	logic                              ignored;

	modport source (output valid, drive_value, drive_written, mean_value, var_value,
		trip_flag, ignored, input ready);
	modport sink   (input valid, drive_value, drive_written, mean_value, var_value,
		trip_flag, ignored, output ready);
endinterface

### rtl/swet_mul.sv
// ----------------------------------------------------------------------------
// swet_mul
// shared signed 27x27 multiplier with registered product
// ----------------------------------------------------------------------------
module swet_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  swet_pkg::mul_req_t                  req,
	output logic signed [swet_pkg::PROD_W-1:0]  prod_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
		end else if (req.en) begin
			prod_q <= req.a * req.b;
		end
	end

endmodule

### rtl/saturating_drive_with_ewma_trip.sv
// ----------------------------------------------------------------------------
// saturating_drive_with_ewma_trip
// scaled, clamped converter drive with weighted mean/variance trip
// ----------------------------------------------------------------------------
// usage:
//   sample carries one request per transaction: a control sample or an end
//   command. result returns exactly one transaction per request, in order.
//   cfg_we/cfg_index/cfg_data write gain_recip (0), max_drive (1),
//   smoothing_alpha (2) and var_threshold (3); write only while idle.
// sequencing:
//   a valid control sample runs through eleven steps of one shared 27x27
//   multiplier and its adders; no new request is taken until the result is
//   registered. end commands, samples after finish and invalid samples skip
//   the arithmetic and go straight to the output step. the chain of
//   dependent products (scale, square, two beta partials, two alpha partials,
//   mean) through the single multiplier sets the length of the sequence.
// reset:
//   statistics cleared, first-sample seeding armed, not finished, config
//   registers back to their defaults, no result pending.
// stall:
//   the result sits in an output register until taken; a new request is
//   accepted meanwhile, and its own result waits in the final step until
//   the output register frees.
// ----------------------------------------------------------------------------
module saturating_drive_with_ewma_trip (
	input  logic                         clk,
	input  logic                         arst_n,
	swet_in_if.sink                      sample,
	swet_out_if.source                   result,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [swet_pkg::VAR_W-1:0]   cfg_data
);

	// register indexes
	localparam logic [1:0] REG_GAIN  = 2'd0;
	localparam logic [1:0] REG_MAXD  = 2'd1;
	localparam logic [1:0] REG_ALPHA = 2'd2;
	localparam logic [1:0] REG_THR   = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_SCALE, S_CLAMP, S_SQ, S_SQR, S_BLO, S_BHI,
		S_T, S_ALO, S_AHI, S_VAR, S_OUT
	} state_t;

	// what kind of result the current transaction produces
	typedef enum logic [1:0] {K_END, K_IGN, K_BAD, K_SAMPLE} kind_t;

	// configuration
	logic [15:0] gain_q;
	logic [22:0] maxd_q;
	logic [15:0] alpha_q;
	logic [31:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= 16'd4096;
			maxd_q  <= 23'd12288;
			alpha_q <= 16'd64880;
			thr_q   <= 32'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN:  gain_q  <= cfg_data[15:0];
				REG_MAXD:  maxd_q  <= cfg_data[22:0];
				REG_ALPHA: alpha_q <= cfg_data[15:0];
				REG_THR:   thr_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	state_t             state_q;
	kind_t              kind_q;
	logic signed [23:0] ca_q;
	logic               finished_q;
	logic               first_q;
	logic signed [23:0] mean_q;
	logic [31:0]        var_q;
	logic signed [23:0] v_q;
	logic signed [24:0] diff_q;
	logic [36:0]        sq_q;
	logic [38:0]        s_q;
	logic [42:0]        acc_q;

	// output register
	logic               out_valid_q;
	logic signed [23:0] out_drive_q;
	logic               out_written_q;
	logic signed [23:0] out_mean_q;
	logic [31:0]        out_var_q;
	logic               out_end_q;
	logic               out_ign_q;

	// shared multiplier
	swet_pkg::mul_req_t                  mul_req;
	logic signed [swet_pkg::PROD_W-1:0]  prod_q;

	swet_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.prod_q (prod_q)
	);

	// (1 - alpha) in Q1.16, 65536 when alpha is zero
	logic [16:0] beta;
	assign beta = 17'd65536 - {1'b0, alpha_q};

	always_comb begin
		mul_req = '0;
		case (state_q)
			S_SCALE: begin
				mul_req.en = 1'b1;
				mul_req.a  = {{3{ca_q[23]}}, ca_q};
				mul_req.b  = {11'b0, gain_q};
			end
			S_SQ: begin
				mul_req.en = 1'b1;
				mul_req.a  = {{2{diff_q[24]}}, diff_q};
				mul_req.b  = {{2{diff_q[24]}}, diff_q};
			end
			S_SQR: begin
				mul_req.en = 1'b1;
				mul_req.a  = {10'b0, beta};
				mul_req.b  = {{2{diff_q[24]}}, diff_q};
			end
			S_BLO: begin
				mul_req.en = 1'b1;
				mul_req.a  = {10'b0, beta};
				mul_req.b  = {1'b0, sq_q[25:0]};
			end
			S_BHI: begin
				mul_req.en = 1'b1;
				mul_req.a  = {10'b0, beta};
				mul_req.b  = {16'b0, sq_q[36:26]};
			end
			S_ALO: begin
				mul_req.en = 1'b1;
				mul_req.a  = {11'b0, alpha_q};
				mul_req.b  = {1'b0, s_q[25:0]};
			end
			S_AHI: begin
				mul_req.en = 1'b1;
				mul_req.a  = {11'b0, alpha_q};
				mul_req.b  = {14'b0, s_q[38:26]};
			end
			default: mul_req = '0;
		endcase
	end

	// rounding at 2^12: scaled drive and squared difference
	logic signed [53:0] round12;
	assign round12 = prod_q + 54'sd2048;

	// scaled sample, clamped to plus or minus max_drive
	logic signed [41:0] v_full;
	logic signed [41:0] lim_s;
	logic signed [41:0] v_sel;
	logic signed [23:0] v_new;
	logic signed [23:0] mean_eff;
	logic signed [24:0] diff_new;

	always_comb begin
		v_full = $signed(round12[53:12]);
		lim_s  = $signed({19'b0, maxd_q});
		if (v_full > lim_s) begin
			v_sel = lim_s;
		end else if (v_full < -lim_s) begin
			v_sel = -lim_s;
		end else begin
			v_sel = v_full;
		end
		v_new    = v_sel[23:0];
		// first valid sample seeds the mean
		mean_eff = first_q ? v_new : mean_q;
		diff_new = {v_new[23], v_new} - {mean_eff[23], mean_eff};
	end

	// mean step, rounded at 2^16
	logic signed [53:0] round16;
	assign round16 = prod_q + 54'sd32768;

	// recombine low and high partial products, rounded at 2^16
	logic [55:0] wsum;
	logic [39:0] wq;
	assign wsum = {13'b0, acc_q} + {1'b0, prod_q[28:0], 26'b0} + 56'd32768;
	assign wq   = wsum[55:16];

	logic out_free;
	logic trip;
	assign out_free = !out_valid_q || result.ready;
	assign trip     = var_q > thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			kind_q        <= K_IGN;
			ca_q          <= '0;
			finished_q    <= 1'b0;
			first_q       <= 1'b1;
			mean_q        <= '0;
			var_q         <= '0;
			v_q           <= '0;
			diff_q        <= '0;
			sq_q          <= '0;
			s_q           <= '0;
			acc_q         <= '0;
			out_valid_q   <= 1'b0;
			out_drive_q   <= '0;
			out_written_q <= 1'b0;
			out_mean_q    <= '0;
			out_var_q     <= '0;
			out_end_q     <= 1'b0;
			out_ign_q     <= 1'b0;
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						ca_q <= sample.ctrl_sample;
						if (sample.req_type) begin
							kind_q  <= K_END;
							state_q <= S_OUT;
						end else if (finished_q) begin
							kind_q  <= K_IGN;
							state_q <= S_OUT;
						end else if (sample.sample_invalid) begin
							kind_q  <= K_BAD;
							state_q <= S_OUT;
						end else begin
							kind_q  <= K_SAMPLE;
							state_q <= S_SCALE;
						end
					end
				end
				S_SCALE: state_q <= S_CLAMP;
				S_CLAMP: begin
					v_q     <= v_new;
					diff_q  <= diff_new;
					mean_q  <= mean_eff;
					first_q <= 1'b0;
					state_q <= S_SQ;
				end
				S_SQ: state_q <= S_SQR;
				S_SQR: begin
					sq_q    <= round12[48:12];
					state_q <= S_BLO;
				end
				S_BLO: begin
					// product holds beta * diff here
					mean_q  <= mean_q + round16[39:16];
					state_q <= S_BHI;
				end
				S_BHI: begin
					acc_q   <= prod_q[42:0];
					state_q <= S_T;
				end
				S_T: begin
					s_q     <= {7'b0, var_q} + wq[38:0];
					state_q <= S_ALO;
				end
				S_ALO: state_q <= S_AHI;
				S_AHI: begin
					acc_q   <= prod_q[42:0];
					state_q <= S_VAR;
				end
				S_VAR: begin
					// saturate to 32 bits
					var_q   <= (wq[39:32] != 8'd0) ? 32'hFFFF_FFFF : wq[31:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_mean_q    <= mean_q;
						out_var_q     <= var_q;
						out_drive_q   <= '0;
						out_written_q <= 1'b0;
						out_end_q     <= 1'b0;
						out_ign_q     <= 1'b0;
						case (kind_q)
							K_END: begin
								out_written_q <= 1'b1;
								finished_q    <= 1'b1;
							end
							K_IGN: out_ign_q <= 1'b1;
							K_BAD: begin
								out_end_q  <= 1'b1;
								finished_q <= 1'b1;
							end
							K_SAMPLE: begin
								if (trip) begin
									out_end_q  <= 1'b1;
									finished_q <= 1'b1;
								end else begin
									out_drive_q   <= v_q;
									out_written_q <= 1'b1;
								end
							end
							default: ;
						endcase
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample.ready         = (state_q == S_IDLE);
	assign result.valid         = out_valid_q;
	assign result.drive_value   = out_drive_q;
	assign result.drive_written = out_written_q;
	assign result.mean_value    = out_mean_q;
	assign result.var_value     = out_var_q;
	assign result.trip_flag     = out_end_q;
	assign result.ignored       = out_ign_q;

endmodule

### rtl/swet_checker.sv
// ----------------------------------------------------------------------------
// swet_checker
// port-level checks of the saturating drive block, bound to the top level
// ----------------------------------------------------------------------------
`include "saturating_drive_with_ewma_trip_macros.svh"

module swet_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] drive_value,
	input logic        drive_written,
	input logic        trip_flag,
	input logic        ignored
);

	// a held result stays offered
	`SWET_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

	// one request at a time: busy right after a transaction is taken
	`SWET_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// a trip or invalid sample never writes the converter
	`SWET_ASSERT_SAME(a_end_no_write, out_valid && trip_flag, !drive_written && !ignored)

	// no drive value without a write
	`SWET_ASSERT_SAME(a_zero_unwritten, out_valid && !drive_written, drive_value == 24'd0)

	// a dropped sample reports nothing else
	`SWET_ASSERT_SAME(a_ignored_quiet, out_valid && ignored, !drive_written && !trip_flag)

endmodule

bind saturating_drive_with_ewma_trip swet_checker u_swet_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (sample.valid),
	.in_ready      (sample.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.drive_value   (result.drive_value),
	.drive_written (result.drive_written),
	.trip_flag     (result.trip_flag),
	.ignored       (result.ignored)
);
